FILE: hdl/shabsh_pkg.sv
package shabsh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic       wr_byte;
    logic [7:0] byte_val;
    logic [5:0] pos;
    logic       add_len;
    logic       wr_len;
    logic       init_work;
    logic       round_en;
    logic [5:0] rnd;
    logic       fold;
    logic       clear;
    logic [2:0] out_idx;
  } dp_cmd_t;

  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam logic [5:0] LAST_POS     = 6'd63;
  localparam logic [5:0] LAST_ROUND   = 6'd63;
  localparam logic [2:0] LAST_WORD    = 3'd7;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

FILE: hdl/shabsh_ctrl.sv
module shabsh_ctrl
  import shabsh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PAD80 = 8'b0000_0010,
    S_PADZ  = 8'b0000_0100,
    S_LEN   = 8'b0000_1000,
    S_INIT  = 8'b0001_0000,
    S_RND   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic       fin_pend_r, fin_pend_nxt;
  logic       pad_r, pad_nxt;
  logic       ovf_r, ovf_nxt;
  logic       final_r, final_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    rnd_nxt      = rnd_r;
    oidx_nxt     = oidx_r;
    fin_pend_nxt = fin_pend_r;
    pad_nxt      = pad_r;
    ovf_nxt      = ovf_r;
    final_nxt    = final_r;
    cmd          = '0;
    cmd.pos      = fill_r;
    cmd.rnd      = rnd_r;
    cmd.out_idx  = oidx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.byte_valid) begin
            cmd.wr_byte  = 1'b1;
            cmd.byte_val = in_data.data_byte;
            cmd.add_len  = 1'b1;
            fill_nxt     = fill_r + 6'd1;
            if (fill_r == LAST_POS) begin
              state_nxt    = S_INIT;
              fin_pend_nxt = in_data.end_of_message;
            end else if (in_data.end_of_message) begin
              state_nxt = S_PAD80;
            end
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.wr_byte  = 1'b1;
        cmd.byte_val = PAD_BYTE;
        ovf_nxt      = (fill_r >= LEN_POS);
        pad_nxt      = 1'b1;
        fill_nxt     = fill_r + 6'd1;
        state_nxt    = S_PADZ;
      end
      S_PADZ: begin
        if (ovf_r) begin
          if (fill_r == 6'd0) begin
            ovf_nxt   = 1'b0;
            state_nxt = S_INIT;
          end else begin
            cmd.wr_byte = 1'b1;
            fill_nxt    = fill_r + 6'd1;
          end
        end else if (fill_r == LEN_POS) begin
          state_nxt = S_LEN;
        end else begin
          cmd.wr_byte = 1'b1;
          fill_nxt    = fill_r + 6'd1;
        end
      end
      S_LEN: begin
        cmd.wr_len = 1'b1;
        final_nxt  = 1'b1;
        state_nxt  = S_INIT;
      end
      S_INIT: begin
        cmd.init_work = 1'b1;
        rnd_nxt       = 6'd0;
        state_nxt     = S_RND;
      end
      S_RND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fold = 1'b1;
        if (final_r) begin
          oidx_nxt  = 3'd0;
          state_nxt = S_OUT;
        end else if (pad_r) begin
          state_nxt = S_PADZ;
        end else if (fin_pend_r) begin
          state_nxt = S_PAD80;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == LAST_WORD) begin
            cmd.clear    = 1'b1;
            fill_nxt     = 6'd0;
            fin_pend_nxt = 1'b0;
            pad_nxt      = 1'b0;
            ovf_nxt      = 1'b0;
            final_nxt    = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= 6'd0;
      rnd_r      <= 6'd0;
      oidx_r     <= 3'd0;
      fin_pend_r <= 1'b0;
      pad_r      <= 1'b0;
      ovf_r      <= 1'b0;
      final_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      rnd_r      <= rnd_nxt;
      oidx_r     <= oidx_nxt;
      fin_pend_r <= fin_pend_nxt;
      pad_r      <= pad_nxt;
      ovf_r      <= ovf_nxt;
      final_r    <= final_nxt;
    end
  end

endmodule

FILE: hdl/shabsh_dp.sv
module shabsh_dp
  import shabsh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output out_item_t out_data
);

  logic [31:0] win_r   [16];
  logic [31:0] work_r  [8];
  logic [31:0] chain_r [8];
  logic [63:0] total_r;

  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;
  logic [31:0] sml_s0, sml_s1, w_new;
  logic [31:0] lane_word;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    big_s1 = rotr(work_r[4], 6) ^ rotr(work_r[4], 11) ^ rotr(work_r[4], 25);
    ch     = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    t1     = work_r[7] + big_s1 + ch + K_TAB[cmd.rnd] + win_r[0];
    big_s0 = rotr(work_r[0], 2) ^ rotr(work_r[0], 13) ^ rotr(work_r[0], 22);
    maj    = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t2     = big_s0 + maj;
    sml_s0 = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    sml_s1 = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    w_new  = sml_s1 + win_r[9] + sml_s0 + win_r[0];
    lane_word = {cmd.byte_val, 24'h0} >> {cmd.pos[1:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= w_new;
    end else if (cmd.wr_len) begin
      win_r[14] <= total_r[63:32];
      win_r[15] <= total_r[31:0];
    end else if (cmd.wr_byte) begin
      if (cmd.pos[1:0] == 2'd0) begin
        win_r[cmd.pos[5:2]] <= lane_word;
      end else begin
        win_r[cmd.pos[5:2]] <= win_r[cmd.pos[5:2]] | lane_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_work) begin
      for (int i = 0; i < 8; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (cmd.round_en) begin
      work_r[0] <= t1 + t2;
      work_r[1] <= work_r[0];
      work_r[2] <= work_r[1];
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3] + t1;
      work_r[5] <= work_r[4];
      work_r[6] <= work_r[5];
      work_r[7] <= work_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= IV_TAB[i];
      end
      total_r <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + work_r[i];
        end
      end
      if (cmd.add_len) begin
        total_r <= total_r + BITS_PER_BYTE;
      end
    end
  end

  assign out_data.digest_word = chain_r[cmd.out_idx];
  assign out_data.word_index  = cmd.out_idx;
  assign out_data.last_word   = (cmd.out_idx == LAST_WORD);

endmodule

FILE: hdl/sha256_byte_stream_hasher_core.sv
// Message bytes: one item per cycle while idle; every 64th byte stalls the input
// for a block compression (load, 64 rounds of the single round unit, chain update).
// End of message: padding (0x80 byte, zero bytes, 64-bit bit count), one or two
// compressions, then eight digest items, one per cycle while the output is not stalled.
// Synchronous active-low reset restores the initial chain value and clears the
// byte and bit counts; the block store needs no clearing and is ready at once.
module sha256_byte_stream_hasher_core
  import shabsh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t cmd;

  shabsh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  shabsh_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .out_data (out_data)
  );

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("input item accepted while digest is being emitted");

  a_no_write_during_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_en |-> (!cmd.wr_byte && !cmd.wr_len && !cmd.add_len))
    else $error("block store written during compression rounds");

  a_idle_after_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_word) |=> (!out_valid && !in_stall))
    else $error("block not idle after final digest word");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

endmodule
